// File: design/mctt_pkg.sv
// ----------------------------------------------------------------------------
// mctt_pkg - shared definitions for the multi-channel timeout timer
// Channel bank sizes, field widths, request/result codes and the
// command/status structs between controller and datapath.
// ----------------------------------------------------------------------------
package mctt_pkg;

  localparam int RELOAD_CHANNELS = 12;
  localparam int LOCAL_CHANNELS  = 4;
  localparam int TOTAL_CHANNELS  = RELOAD_CHANNELS + LOCAL_CHANNELS;
  localparam int COUNT_BITS      = 16;
  localparam int CH_W            = 4;   // channel field width
  localparam int DUR_W           = 16;  // duration field width
  localparam int REM_W           = 16;  // remaining_count field width
  localparam int SUB_BITS        = 16;
  localparam int SEC_BITS        = 32;
  localparam int IDX_W           = (TOTAL_CHANNELS > 1) ? $clog2(TOTAL_CHANNELS) : 1;
  localparam int RL_W            = (RELOAD_CHANNELS > 1) ? $clog2(RELOAD_CHANNELS) : 1;
  localparam int CHK_W           = ((IDX_W > CH_W) ? IDX_W : CH_W) + 1;

  localparam logic [SUB_BITS-1:0] DIV_LIMIT_RESET = 16'd800;

  // Input request codes (s_tuser)
  typedef enum logic [1:0] {
    REQ_TICK  = 2'd0,
    REQ_START = 2'd1,
    REQ_STOP  = 2'd2
  } req_e;

  // Result codes (m_tuser)
  typedef enum logic [1:0] {
    KIND_EXPIRY = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_TDONE  = 2'd3
  } kind_e;

  // Datapath operations
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_SCAN  = 3'd1,
    OP_TDONE = 3'd2,
    OP_START = 3'd3,
    OP_STOP  = 3'd4
  } op_e;

  typedef struct packed {
    logic             load;  // capture input item fields
    op_e              op;
    logic [IDX_W-1:0] idx;   // scan position
  } cmd_t;

  typedef struct packed {
    logic out_free;          // output register can take a result this cycle
  } stat_t;

endpackage

// File: design/mctt_ctrl.sv
// ----------------------------------------------------------------------------
// mctt_ctrl - request sequencer
// Accepts one item at a time and steps the datapath through a tick scan
// or a single start/stop operation, pacing on output register space.
// ----------------------------------------------------------------------------
module mctt_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  mctt_pkg::req_e     req_type,
  output logic               in_ready,
  input  mctt_pkg::stat_t    stat,
  output mctt_pkg::cmd_t     cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_TDONE,
    ST_OP
  } state_t;

  localparam logic [mctt_pkg::IDX_W-1:0] IDX_LAST =
    mctt_pkg::IDX_W'(mctt_pkg::TOTAL_CHANNELS - 1);

  state_t                       state;
  state_t                       state_next;
  logic [mctt_pkg::IDX_W-1:0]   idx;
  logic [mctt_pkg::IDX_W-1:0]   idx_next;
  mctt_pkg::op_e                pend_op;
  mctt_pkg::op_e                pend_op_next;

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    pend_op_next = pend_op;
    in_ready     = 1'b0;
    cmd.load     = 1'b0;
    cmd.op       = mctt_pkg::OP_NONE;
    cmd.idx      = idx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          case (req_type)
            mctt_pkg::REQ_TICK: begin
              idx_next   = '0;
              state_next = ST_SCAN;
            end
            mctt_pkg::REQ_START: begin
              pend_op_next = mctt_pkg::OP_START;
              state_next   = ST_OP;
            end
            mctt_pkg::REQ_STOP: begin
              pend_op_next = mctt_pkg::OP_STOP;
              state_next   = ST_OP;
            end
            default: state_next = ST_IDLE;  // reserved code: dropped
          endcase
        end
      end
      ST_SCAN: begin
        if (stat.out_free) begin
          cmd.op = mctt_pkg::OP_SCAN;
          if (idx == IDX_LAST) begin
            state_next = ST_TDONE;
          end else begin
            idx_next = idx + 1'b1;
          end
        end
      end
      ST_TDONE: begin
        if (stat.out_free) begin
          cmd.op     = mctt_pkg::OP_TDONE;
          state_next = ST_IDLE;
        end
      end
      ST_OP: begin
        if (stat.out_free) begin
          cmd.op     = pend_op;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      idx     <= '0;
      pend_op <= mctt_pkg::OP_NONE;
    end else begin
      state   <= state_next;
      idx     <= idx_next;
      pend_op <= pend_op_next;
    end
  end

endmodule

// File: design/mctt_dp.sv
// ----------------------------------------------------------------------------
// mctt_dp - channel bank and result datapath
// Holds channel counts, reload periods, the seconds divider and the
// output register; executes one operation per command.
// ----------------------------------------------------------------------------
module mctt_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mctt_pkg::cmd_t                  cmd,
  output mctt_pkg::stat_t                 stat,
  input  logic [mctt_pkg::CH_W-1:0]       in_channel,
  input  logic [mctt_pkg::DUR_W-1:0]      in_duration,
  input  logic                            in_periodic,
  input  logic [mctt_pkg::SUB_BITS-1:0]   div_limit,
  output logic                            out_valid,
  input  logic                            out_ready,
  output mctt_pkg::kind_e                 out_kind,
  output logic [mctt_pkg::CH_W-1:0]       out_channel,
  output logic [mctt_pkg::REM_W-1:0]      out_remaining,
  output logic [mctt_pkg::SEC_BITS-1:0]   out_uptime,
  output logic                            out_last
);

  localparam int CB = mctt_pkg::COUNT_BITS;

  logic [CB-1:0]                  counts  [mctt_pkg::TOTAL_CHANNELS];
  logic [CB-1:0]                  periods [mctt_pkg::RELOAD_CHANNELS];
  logic [mctt_pkg::SUB_BITS-1:0]  subcount;
  logic [mctt_pkg::SEC_BITS-1:0]  seconds;

  // captured item
  logic [mctt_pkg::CH_W-1:0]      chan_q;
  logic [CB-1:0]                  dur_q;
  logic                           per_q;

  logic [mctt_pkg::IDX_W-1:0]     rd_idx;
  logic [mctt_pkg::CHK_W-1:0]     rd_wide;
  logic                           in_bank;
  logic                           in_reload;
  logic [CB-1:0]                  cnt_rd;
  logic [CB-1:0]                  per_rd;
  logic [CB-1:0]                  cnt_dec;
  logic [mctt_pkg::SUB_BITS-1:0]  sub_inc;
  logic                           sec_tick;

  assign stat.out_free = !out_valid || out_ready;

  // one read port: scan position during a tick, captured channel otherwise
  always_comb begin
    if (cmd.op == mctt_pkg::OP_SCAN) begin
      rd_idx  = cmd.idx;
      rd_wide = mctt_pkg::CHK_W'(cmd.idx);
    end else begin
      rd_idx  = mctt_pkg::IDX_W'(chan_q);
      rd_wide = mctt_pkg::CHK_W'(chan_q);
    end
    in_bank   = rd_wide < mctt_pkg::CHK_W'(mctt_pkg::TOTAL_CHANNELS);
    in_reload = rd_wide < mctt_pkg::CHK_W'(mctt_pkg::RELOAD_CHANNELS);
    cnt_rd    = in_bank ? counts[rd_idx] : '0;
    per_rd    = in_reload ? periods[rd_idx[mctt_pkg::RL_W-1:0]] : '0;
    cnt_dec   = cnt_rd - 1'b1;
    sub_inc   = subcount + 1'b1;
    sec_tick  = sub_inc > div_limit;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      chan_q <= in_channel;
      dur_q  <= CB'(in_duration);
      per_q  <= in_periodic;
    end
  end

  // channel bank and divider
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < mctt_pkg::TOTAL_CHANNELS; i++) begin
        counts[i] <= '0;
      end
      for (int i = 0; i < mctt_pkg::RELOAD_CHANNELS; i++) begin
        periods[i] <= '0;
      end
      subcount <= '0;
      seconds  <= '0;
    end else begin
      case (cmd.op)
        mctt_pkg::OP_SCAN: begin
          if (in_bank && cnt_rd != '0) begin
            counts[rd_idx] <= (cnt_dec == '0) ? per_rd : cnt_dec;
          end
        end
        mctt_pkg::OP_TDONE: begin
          if (sec_tick) begin
            subcount <= '0;
            seconds  <= seconds + 1'b1;
          end else begin
            subcount <= sub_inc;
          end
        end
        mctt_pkg::OP_START: begin
          if (in_bank) begin
            counts[rd_idx] <= dur_q + 1'b1;
          end
          if (in_reload) begin
            periods[rd_idx[mctt_pkg::RL_W-1:0]] <= per_q ? dur_q : '0;
          end
        end
        mctt_pkg::OP_STOP: begin
          if (in_bank) begin
            counts[rd_idx] <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      case (cmd.op)
        mctt_pkg::OP_SCAN: begin
          if (in_bank && cnt_rd != '0 && cnt_dec == '0) begin
            out_valid <= 1'b1;
          end else if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
        mctt_pkg::OP_TDONE, mctt_pkg::OP_START, mctt_pkg::OP_STOP: begin
          out_valid <= 1'b1;
        end
        default: begin
          if (out_ready) begin
            out_valid <= 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      mctt_pkg::OP_SCAN: begin
        if (in_bank && cnt_rd != '0 && cnt_dec == '0) begin
          out_kind      <= mctt_pkg::KIND_EXPIRY;
          out_channel   <= mctt_pkg::CH_W'(rd_idx);
          out_remaining <= '0;
          out_uptime    <= '0;
          out_last      <= 1'b0;
        end
      end
      mctt_pkg::OP_TDONE: begin
        out_kind      <= mctt_pkg::KIND_TDONE;
        out_channel   <= '0;
        out_remaining <= '0;
        out_uptime    <= sec_tick ? seconds + 1'b1 : seconds;
        out_last      <= 1'b1;
      end
      mctt_pkg::OP_START: begin
        out_kind      <= mctt_pkg::KIND_START;
        out_channel   <= chan_q;
        out_remaining <= '0;
        out_uptime    <= '0;
        out_last      <= 1'b1;
      end
      mctt_pkg::OP_STOP: begin
        out_kind      <= mctt_pkg::KIND_STOP;
        out_channel   <= chan_q;
        out_remaining <= mctt_pkg::REM_W'(cnt_rd);
        out_uptime    <= '0;
        out_last      <= 1'b1;
      end
      default: ;
    endcase
  end

endmodule

// File: design/multi_channel_timeout_timer_top.sv
// ----------------------------------------------------------------------------
// multi_channel_timeout_timer_top - bank of countdown timeout channels
// Sixteen countdown channels (twelve reloadable, four one-shot local),
// driven by tick/start/stop request items, with an uptime seconds counter.
// ----------------------------------------------------------------------------
// Usage:
//   s_* stream: one request item per handshake. s_tuser is the request
//     (tick, start, stop); s_tdata carries channel, duration, periodic.
//   m_* stream: result items. m_tuser is the result kind; m_tlast marks the
//     final result of a request item.
//   APB port: register 0 (byte address 0) is second_divider_limit, 16 bits,
//     reset 800. Write it only while the block is idle.
// Sequencing:
//   Start or stop: the item is accepted, then the operation is issued once
//     the output register is free and its result is registered.
//   Tick: the item is accepted, then one channel per cycle while the output
//     register has space, as the sequencer walks the single read port of the
//     channel bank, then the tick-done result. Each expiry is emitted during the
//     walk, in channel order, before tick done.
//   A reserved request code is taken and produces no result.
// Reset: all channels idle, periods and counters zero, limit 800.
// Stall: results sit in a single output register; while it is full and
//   m_tready is low the sequencer holds its position. s_tready is high
//   only between items, so a new item may be taken while the last result
//   of the previous one still waits.
// ----------------------------------------------------------------------------
module multi_channel_timeout_timer_top (
  input  logic        clk,
  input  logic        rst,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // [3:0] channel, [19:4] duration, [20] periodic
  input  logic [1:0]  s_tuser,   // [1:0] req_type
  // result stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [55:0] m_tdata,   // [3:0] result_channel, [19:4] remaining_count,
                                 // [51:20] uptime_seconds
  output logic [1:0]  m_tuser,   // [1:0] result_kind
  output logic        m_tlast,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  mctt_pkg::cmd_t                  cmd;
  mctt_pkg::stat_t                 stat;
  mctt_pkg::kind_e                 out_kind;
  logic [mctt_pkg::CH_W-1:0]       out_channel;
  logic [mctt_pkg::REM_W-1:0]      out_remaining;
  logic [mctt_pkg::SEC_BITS-1:0]   out_uptime;
  logic [mctt_pkg::SUB_BITS-1:0]   div_limit;

  // ---- configuration register ----
  // register index is paddr / 4; only index 0 exists
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_limit <= mctt_pkg::DIV_LIMIT_RESET;
    end else if (psel && penable && pwrite && !paddr[2]) begin
      div_limit <= pwdata[mctt_pkg::SUB_BITS-1:0];
    end
  end

  assign prdata = paddr[2] ? 32'd0 : 32'(div_limit);

  // ---- sequencer ----
  mctt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .req_type (mctt_pkg::req_e'(s_tuser)),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  // ---- channel bank / results ----
  mctt_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_channel    (s_tdata[3:0]),
    .in_duration   (s_tdata[19:4]),
    .in_periodic   (s_tdata[20]),
    .div_limit     (div_limit),
    .out_valid     (m_tvalid),
    .out_ready     (m_tready),
    .out_kind      (out_kind),
    .out_channel   (out_channel),
    .out_remaining (out_remaining),
    .out_uptime    (out_uptime),
    .out_last      (m_tlast)
  );

  assign m_tuser = out_kind;
  assign m_tdata = {4'b0000, out_uptime, out_remaining, out_channel};

  // ---- assertions ----
  // start/stop occupies the sequencer for its result cycle
  a_op_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready &&
    (s_tuser == mctt_pkg::REQ_START || s_tuser == mctt_pkg::REQ_STOP)
    |=> !s_tready)
    else $error("sequencer took a new item during start/stop");

  // only expiries are non-final; every other kind closes its item
  a_last_kind: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tlast == (out_kind != mctt_pkg::KIND_EXPIRY)))
    else $error("tlast does not match result kind");

  // remaining count only on stop readback
  a_rem_stop: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_kind != mctt_pkg::KIND_STOP |-> out_remaining == '0)
    else $error("remaining count on non-stop result");

  // a tick is not taken while a previous tick's scan is still running
  a_tick_gap: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser == mctt_pkg::REQ_TICK |=> ##1 !s_tready)
    else $error("tick scan ended early");

endmodule

// File: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top - testbench for the multi-channel timeout timer
// Drives tick/start/stop request items into the block, predicts each result
// (expiries, start acks, stop readbacks, tick-done with uptime seconds) and
// compares results in order. The divider limit register is set over APB
// between phases. The request and result sides stall at random.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  // Reserved request code: accepted by the block, produces nothing.
  localparam logic [1:0] REQ_RESERVED   = 2'd3;
  // APB byte address of second_divider_limit (register 0).
  localparam logic [2:0] DIV_LIMIT_ADDR = 3'd0;
  // A tick walks all channels: accept, a scan of every channel, then tick done.
  localparam int DRAIN_CYCLES = 20;
  // Cycles with no handshake on any port before the run is declared hung.
  localparam int STALL_LIMIT  = 2000;

  typedef struct {
    mctt_pkg::kind_e                 kind;
    logic [mctt_pkg::CH_W-1:0]       chan;
    logic [mctt_pkg::REM_W-1:0]      remaining;
    logic [mctt_pkg::SEC_BITS-1:0]   uptime;
    logic                            last;
  } timer_result_t;

  // --------------------------------------------------------------------------
  // Clock, reset and block ports
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;

  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;   // [3:0] channel, [19:4] duration, [20] periodic
  logic [1:0]  s_tuser  = '0;   // [1:0] req_type

  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [55:0] m_tdata;         // [3:0] result_channel, [19:4] remaining_count,
                                // [51:20] uptime_seconds
  logic [1:0]  m_tuser;         // [1:0] result_kind
  logic        m_tlast;

  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [2:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic [31:0] prdata;
  logic        pready;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  multi_channel_timeout_timer_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // --------------------------------------------------------------------------
  // Timer predictor: private copy of the channel bank and uptime counters.
  // Updated at the edge where a request item is accepted.
  // --------------------------------------------------------------------------
  logic [mctt_pkg::COUNT_BITS-1:0] chan_count  [mctt_pkg::TOTAL_CHANNELS];
  logic [mctt_pkg::COUNT_BITS-1:0] chan_period [mctt_pkg::RELOAD_CHANNELS];
  logic [mctt_pkg::SUB_BITS-1:0]   tick_subcount = '0;
  logic [mctt_pkg::SEC_BITS-1:0]   uptime_secs   = '0;
  logic [mctt_pkg::SUB_BITS-1:0]   div_limit     = mctt_pkg::DIV_LIMIT_RESET;

  timer_result_t pending_results[$];   // expected results, oldest first
  timer_result_t oldest_result;

  int send_idle_pct = 0;   // chance per cycle that the request side idles
  int recv_idle_pct = 0;   // chance per cycle that the result side stalls
  int mismatch_count = 0;
  int quiet_cycles = 0;

  initial begin
    for (int i = 0; i < mctt_pkg::TOTAL_CHANNELS; i++) chan_count[i] = '0;
    for (int i = 0; i < mctt_pkg::RELOAD_CHANNELS; i++) chan_period[i] = '0;
  end

  task automatic push_result(input mctt_pkg::kind_e kind,
                             input logic [mctt_pkg::CH_W-1:0] chan,
                             input logic [mctt_pkg::REM_W-1:0] remaining,
                             input logic [mctt_pkg::SEC_BITS-1:0] uptime,
                             input logic last);
    timer_result_t r;
    r.kind      = kind;
    r.chan      = chan;
    r.remaining = remaining;
    r.uptime    = uptime;
    r.last      = last;
    pending_results.push_back(r);
  endtask

  task automatic predict_request(input logic [1:0] req,
                                 input logic [mctt_pkg::CH_W-1:0] chan,
                                 input logic [mctt_pkg::DUR_W-1:0] dur,
                                 input logic periodic);
    logic [mctt_pkg::COUNT_BITS-1:0] held;
    held = '0;
    case (req)
      mctt_pkg::REQ_TICK: begin
        // Walk the bank in index order; every channel reaching zero expires.
        for (int i = 0; i < mctt_pkg::TOTAL_CHANNELS; i++) begin
          if (chan_count[i] != '0) begin
            chan_count[i] = chan_count[i] - 1'b1;
            if (chan_count[i] == '0) begin
              if (i < mctt_pkg::RELOAD_CHANNELS) chan_count[i] = chan_period[i];
              push_result(mctt_pkg::KIND_EXPIRY, mctt_pkg::CH_W'(i), '0, '0, 1'b0);
            end
          end
        end
        // Sub-counter wraps at 16 bits; with limit 65535 seconds never move.
        tick_subcount = tick_subcount + 1'b1;
        if (tick_subcount > div_limit) begin
          tick_subcount = '0;
          uptime_secs   = uptime_secs + 1'b1;
        end
        push_result(mctt_pkg::KIND_TDONE, '0, '0, uptime_secs, 1'b1);
      end
      mctt_pkg::REQ_START: begin
        if (chan < mctt_pkg::TOTAL_CHANNELS) begin
          // Local channels keep no period; all-ones duration wraps to idle.
          if (chan < mctt_pkg::RELOAD_CHANNELS) chan_period[chan] = periodic ? dur : '0;
          chan_count[chan] = dur + 1'b1;
        end
        push_result(mctt_pkg::KIND_START, chan, '0, '0, 1'b1);
      end
      mctt_pkg::REQ_STOP: begin
        if (chan < mctt_pkg::TOTAL_CHANNELS) begin
          held = chan_count[chan];
          chan_count[chan] = '0;
        end
        push_result(mctt_pkg::KIND_STOP, chan, held, '0, 1'b1);
      end
      default: ;   // reserved code: no result, no state change
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Request side. Every task is entered just after a rising edge. tvalid is
  // left high after acceptance; the next send either reloads the fields or
  // lowers it in the same step, so each step sees one assignment to it.
  // --------------------------------------------------------------------------
  task automatic send_request(input logic [1:0] req,
                              input logic [mctt_pkg::CH_W-1:0] chan,
                              input logic [mctt_pkg::DUR_W-1:0] dur,
                              input logic periodic);
    int gap;
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= {3'b000, periodic, dur, chan};
    do @(posedge clk); while (!s_tready);
    predict_request(req, chan, dur, periodic);
  endtask

  // Stop sending and wait until every expected result is in, then let the
  // sequencer settle (a reserved item leaves nothing to wait for).
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // APB access: setup cycle, then access cycle until pready.
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == DIV_LIMIT_ADDR) div_limit = data[mctt_pkg::SUB_BITS-1:0];
  endtask

  task automatic apb_read_check(input logic [2:0] addr, input logic [31:0] want);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) report_mismatch("register readback", prdata, want);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_div_limit(input logic [mctt_pkg::SUB_BITS-1:0] limit);
    drain_results();
    apb_write(DIV_LIMIT_ADDR, {16'h0000, limit});
    // psel drops between the two transfers
    @(posedge clk);
    apb_read_check(DIV_LIMIT_ADDR, {16'h0000, limit});
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stall, in-order compare against the oldest
  // expectation. Values are read before this edge's updates land.
  // --------------------------------------------------------------------------
  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t ns: mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    mismatch_count++;
  endtask

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending (kind)", 32'(m_tuser), '0);
      end else begin
        oldest_result = pending_results.pop_front();
        if (m_tuser !== oldest_result.kind)
          report_mismatch("result_kind", 32'(m_tuser), 32'(oldest_result.kind));
        if (m_tdata[3:0] !== oldest_result.chan)
          report_mismatch("result_channel", 32'(m_tdata[3:0]),
                          32'(oldest_result.chan));
        if (m_tdata[19:4] !== oldest_result.remaining)
          report_mismatch("remaining_count", 32'(m_tdata[19:4]),
                          32'(oldest_result.remaining));
        if (m_tdata[51:20] !== oldest_result.uptime)
          report_mismatch("uptime_seconds", m_tdata[51:20], oldest_result.uptime);
        if (m_tlast !== oldest_result.last)
          report_mismatch("last", 32'(m_tlast), 32'(oldest_result.last));
      end
    end
  end

  // Hang detector: any handshake or APB activity resets the count.
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || psel) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Limit register comes out of reset at 800; then the low extreme.
  task automatic test_register_reset();
    apb_read_check(DIV_LIMIT_ADDR, {16'h0000, mctt_pkg::DIV_LIMIT_RESET});
    set_div_limit(16'h0000);
  endtask

  // Start/stop readback, including field extremes and the wrap of duration.
  task automatic test_start_stop_readback();
    send_request(mctt_pkg::REQ_START, 4'd0, 16'h0000, 1'b0);
    send_request(mctt_pkg::REQ_STOP, 4'd0, 16'h0000, 1'b0);        // reads back 1
    send_request(mctt_pkg::REQ_START, 4'd15, 16'hFFFE, 1'b1);      // local: periodic ignored
    send_request(mctt_pkg::REQ_STOP, 4'd15, 16'h0000, 1'b0);
    send_request(mctt_pkg::REQ_START, 4'd11, 16'hFFFF, 1'b1);      // all ones wraps to idle
    send_request(mctt_pkg::REQ_STOP, 4'd11, 16'hFFFF, 1'b1);
    send_request(mctt_pkg::REQ_START, 4'd5, 16'h5555, 1'b1);
    send_request(mctt_pkg::REQ_START, 4'd5, 16'hAAAA, 1'b0);       // restart while running
    send_request(mctt_pkg::REQ_STOP, 4'd5, 16'h0000, 1'b0);
    send_request(REQ_RESERVED, 4'd15, 16'hFFFF, 1'b1);             // ignored, no result
  endtask

  // Expiry ordering, reload, periodic with zero duration, local one-shot.
  task automatic test_expiry_and_reload();
    send_request(mctt_pkg::REQ_START, 4'd3, 16'd1, 1'b1);
    send_request(mctt_pkg::REQ_START, 4'd12, 16'd0, 1'b1);
    send_request(mctt_pkg::REQ_START, 4'd7, 16'd0, 1'b1);
    repeat (3) send_request(mctt_pkg::REQ_TICK, 4'd0, 16'd0, 1'b0);
    send_request(mctt_pkg::REQ_STOP, 4'd3, 16'd0, 1'b0);
  endtask

  // Divider limit at maximum: seconds freeze.
  task automatic test_limit_max();
    set_div_limit(16'hFFFF);
    repeat (2) send_request(mctt_pkg::REQ_TICK, 4'd0, 16'd0, 1'b0);
  endtask

  // Random traffic: mostly ticks and short timers so channels keep expiring,
  // some long or all-range durations, a few reserved codes as noise.
  task automatic test_random_phase(input int send_pct, input int recv_pct,
                                   input int item_target, input logic [15:0] limit);
    int accepted;
    int pick;
    logic [mctt_pkg::DUR_W-1:0] dur;
    accepted = 0;
    set_div_limit(limit);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    while (accepted < item_target) begin
      pick = $urandom_range(0, 99);
      dur  = ($urandom_range(0, 9) == 0) ? mctt_pkg::DUR_W'($urandom)
                                         : mctt_pkg::DUR_W'($urandom_range(0, 20));
      if (pick < 45) begin
        send_request(mctt_pkg::REQ_TICK, mctt_pkg::CH_W'($urandom), dur, 1'($urandom));
      end else if (pick < 75) begin
        send_request(mctt_pkg::REQ_START, mctt_pkg::CH_W'($urandom), dur, 1'($urandom));
      end else if (pick < 96) begin
        send_request(mctt_pkg::REQ_STOP, mctt_pkg::CH_W'($urandom), dur, 1'($urandom));
      end else begin
        send_request(REQ_RESERVED, mctt_pkg::CH_W'($urandom), dur, 1'($urandom));
      end
      if (pick < 96) accepted++;
      // Halfway through, hold off until every result is back.
      if (accepted == item_target / 2 && pick < 96) drain_results();
    end
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_register_reset();
    test_start_stop_readback();
    test_expiry_and_reload();
    test_limit_max();
    test_random_phase(10, 75, 117, 16'd3);
    test_random_phase(75, 10, 117, 16'd0);
    test_random_phase(0, 0, 116, 16'($urandom));

    drain_results();
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
